>>> design/ssfg_pkg.sv
// Shared types and constants for the smoothed stereo fader gain block.
// Holds the item structs, the lane control struct, register indexes and fixed-point constants.
// No dependencies.
package ssfg_pkg;

  localparam int SAMPLE_WIDTH = 24;
  localparam int GAIN_W = 31;
  localparam int FADE_W = 25;
  localparam int RATE_W = 32;
  localparam int SPEED_W = 28;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_INDEX_W = 2;

  localparam int DEN_W = 29;
  localparam int QUO_W = 24;
  localparam int NUM_W = 48;
  localparam int DIV_RADIX = 3;
  localparam int DIV_STEPS = QUO_W / DIV_RADIX;

  localparam logic [SPEED_W-1:0] SPEED_FLOOR = 28'd22937600;
  localparam logic [SPEED_W-1:0] SPEED_CAP = 28'd163840000;
  localparam logic [SPEED_W-1:0] DECAY_SUB = 28'd655;
  localparam logic [SPEED_W-1:0] DECAY_LIMIT = 28'd22938255;
  localparam logic [31:0] DECAY_MUL = 32'd4294537799;
  localparam logic [DEN_W-1:0] ONE_Q16 = 29'd65536;
  localparam logic [55:0] UNITY_PRODUCT = 56'h1_0000_0000_0000;
  localparam logic [56:0] GAIN_ROUND = 57'h80_0000;
  localparam logic [57:0] FADE_ROUND = 58'hFFFF_FFFF;
  localparam logic [23:0] DITHER_HALF = 24'h80_0000;

  localparam logic [31:0] SEED_LEFT_RESET = 32'h1234_5678;
  localparam logic [31:0] SEED_RIGHT_RESET = 32'h8765_4321;

  localparam logic [GAIN_W-1:0] TARGET_GAIN_RESET = 31'd16777216;
  localparam logic [FADE_W-1:0] FADE_LEVEL_RESET = 25'd16777216;
  localparam logic [RATE_W-1:0] FADE_RATE_RESET = 32'd24210639;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_TARGET_GAIN,
    REG_FADE_LEVEL,
    REG_FADE_RATE,
    REG_DITHER_ENABLE
  } cfg_reg_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] sample_left;
    logic signed [SAMPLE_WIDTH-1:0] sample_right;
    logic                           block_first;
  } sample_item_t;

  typedef struct packed {
    logic signed [SAMPLE_WIDTH-1:0] out_left;
    logic signed [SAMPLE_WIDTH-1:0] out_right;
  } result_item_t;

  typedef struct packed {
    logic        start;
    logic        unity;
    logic        dither_enable;
    logic [31:0] gain;
  } lane_ctl_t;

endpackage

>>> design/ssfg_divider.sv
// Iterative restoring divider for the gain chase step, three quotient bits per cycle.
// Depends on ssfg_pkg for its widths.
module ssfg_divider (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [ssfg_pkg::NUM_W-1:0]    num,
  input  logic [ssfg_pkg::DEN_W-1:0]    den,
  output logic                          done,
  output logic [ssfg_pkg::QUO_W-1:0]    quot
);

  localparam int RW = ssfg_pkg::DEN_W;
  localparam int LW = ssfg_pkg::NUM_W - ssfg_pkg::QUO_W;
  localparam int R = ssfg_pkg::DIV_RADIX;
  localparam int CW = $clog2(ssfg_pkg::DIV_STEPS);

  logic                        busy;
  logic [CW-1:0]               cnt;
  logic [RW-1:0]               rem;
  logic [ssfg_pkg::QUO_W-1:0]  low;
  logic [ssfg_pkg::DEN_W-1:0]  den_r;
  logic [RW-1:0]               rem_next;
  logic [R-1:0]                qbits;

  always_comb begin
    logic [RW:0] t;
    rem_next = rem;
    qbits = '0;
    for (int i = 0; i < R; i++) begin
      t = {rem_next, low[ssfg_pkg::QUO_W-1-i]};
      if (t >= {1'b0, den_r}) begin
        t = t - {1'b0, den_r};
        qbits[R-1-i] = 1'b1;
      end
      rem_next = t[RW-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt <= CW'(ssfg_pkg::DIV_STEPS - 1);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == '0) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem <= RW'(num[ssfg_pkg::NUM_W-1:ssfg_pkg::QUO_W]);
      low <= num[LW-1:0];
      den_r <= den;
      quot <= '0;
    end else if (busy) begin
      rem <= rem_next;
      low <= {low[ssfg_pkg::QUO_W-1-R:0], {R{1'b0}}};
      quot <= {quot[ssfg_pkg::QUO_W-1-R:0], qbits};
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst) start |-> !busy)
    else $error("Divider started while busy.");
  a_rem_bound: assert property (@(posedge clk) disable iff (rst) done |-> (rem < den_r))
    else $error("Divider remainder not below the divisor.");
`endif

endmodule

>>> design/ssfg_lane.sv
// One channel lane: gain multiply, xorshift dither, requantisation and saturation.
// Depends on ssfg_pkg for the sample width and the lane control struct.
module ssfg_lane (
  input  logic                                   clk,
  input  logic                                   rst,
  input  ssfg_pkg::lane_ctl_t                    ctl,
  input  logic [31:0]                            seed_reset,
  input  logic signed [ssfg_pkg::SAMPLE_WIDTH-1:0] sample,
  output logic                                   done,
  output logic signed [ssfg_pkg::SAMPLE_WIDTH-1:0] result
);

  localparam int SW = ssfg_pkg::SAMPLE_WIDTH;
  localparam int PW = SW + 33;
  localparam int VW = SW + 34;
  localparam int QW = SW + 10;

  function automatic logic [31:0] xorshift(input logic [31:0] s);
    logic [31:0] t;
    t = s ^ (s << 13);
    t = t ^ (t >> 17);
    t = t ^ (t << 5);
    return t;
  endfunction

  logic [31:0]          seed;
  logic                 s1_valid;
  logic                 unity_r;
  logic                 dither_r;
  logic signed [SW-1:0] samp_r;
  logic signed [PW-1:0] prod;
  logic signed [32:0]   gain_s;
  logic [23:0]          dith;
  logic signed [VW-1:0] sum;
  logic [QW-1:0]        quant;
  logic signed [SW-1:0] sat;

  assign gain_s = $signed({1'b0, ctl.gain});
  assign dith = dither_r ? seed[31:8] : ssfg_pkg::DITHER_HALF;
  assign sum = $signed({prod[PW-1], prod}) + $signed({{(VW-24){1'b0}}, dith});
  assign quant = sum[VW-1:24];

  always_comb begin
    if ((&quant[QW-1:SW-1]) || !(|quant[QW-1:SW-1])) begin
      sat = quant[SW-1:0];
    end else if (quant[QW-1]) begin
      sat = {1'b1, {(SW-1){1'b0}}};
    end else begin
      sat = {1'b0, {(SW-1){1'b1}}};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      seed <= seed_reset;
      s1_valid <= 1'b0;
      done <= 1'b0;
    end else begin
      s1_valid <= ctl.start;
      done <= s1_valid;
      if (ctl.start && !ctl.unity) begin
        seed <= xorshift(seed);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      prod <= sample * gain_s;
      unity_r <= ctl.unity;
      dither_r <= ctl.dither_enable;
      samp_r <= sample;
    end
    if (s1_valid) begin
      result <= unity_r ? samp_r : sat;
    end
  end

endmodule

>>> design/smoothed_stereo_fader_gain.sv
// Smoothed stereo fader gain: two one-pole gain smoothers scale a stereo pair per item.
// A new item is taken only after the previous result has been registered at the output.
// The eight-step radix-8 divider of the gain chase step takes up most of each item's time.
// Synchronous reset restores the configuration, smoother state and dither seeds at once.
// Depends on ssfg_pkg, ssfg_divider and ssfg_lane.
module smoothed_stereo_fader_gain (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  cfg_write,
  input  logic [ssfg_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [ssfg_pkg::CFG_DATA_W-1:0]       cfg_data,
  input  logic                                  sample_valid,
  output logic                                  sample_stall,
  input  ssfg_pkg::sample_item_t                sample_item,
  output logic                                  result_valid,
  input  logic                                  result_stall,
  output ssfg_pkg::result_item_t                result_item
);

  localparam int SW = ssfg_pkg::SAMPLE_WIDTH;
  localparam int GW = ssfg_pkg::GAIN_W;
  localparam int FW = ssfg_pkg::FADE_W;
  localparam int PW = ssfg_pkg::SPEED_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DECAY,
    ST_DIVLOAD,
    ST_DIV,
    ST_PROD,
    ST_SCALE,
    ST_LANE,
    ST_OUT
  } state_t;

  state_t state;

  logic [GW-1:0]             target_gain;
  logic [FW-1:0]             fade_level;
  logic [ssfg_pkg::RATE_W-1:0] fade_rate;
  logic                      dither_enable;

  logic [PW-1:0]             chase_speed;
  logic [GW-1:0]             last_target;
  logic [GW-1:0]             gain_chase;
  logic [FW-1:0]             fade_chase;
  logic                      primed;
  logic                      dir_up;
  logic signed [SW-1:0]      samp_l;
  logic signed [SW-1:0]      samp_r;
  logic [55:0]               prod_r;

  logic [PW:0]               speed_dbl;
  logic [PW-1:0]             speed_blk;
  logic [59:0]               decay_prod;
  logic [PW-1:0]             decay_hi;
  logic [FW-1:0]             fade_diff;
  logic [56:0]               fade_prod;
  logic [57:0]               fade_sum;
  logic [FW-1:0]             fade_step;
  logic [GW-1:0]             gain_diff;
  logic [ssfg_pkg::DEN_W-1:0] den;
  logic [ssfg_pkg::NUM_W-1:0] num;
  logic                      div_start;
  logic                      div_done;
  logic [ssfg_pkg::QUO_W-1:0] quot;
  logic [56:0]               gain_round;
  ssfg_pkg::lane_ctl_t       lane_ctl;
  logic                      lane_l_done;
  logic                      lane_r_done;
  logic signed [SW-1:0]      lane_l_result;
  logic signed [SW-1:0]      lane_r_result;
  logic                      accept;

  assign sample_stall = (state != ST_IDLE);
  assign accept = sample_valid && !sample_stall;

  always_comb begin
    if (sample_item.block_first && (target_gain != last_target)) begin
      speed_dbl = {chase_speed, 1'b0};
    end else begin
      speed_dbl = {1'b0, chase_speed};
    end
    if (sample_item.block_first && (speed_dbl > {1'b0, ssfg_pkg::SPEED_CAP})) begin
      speed_blk = ssfg_pkg::SPEED_CAP;
    end else begin
      speed_blk = speed_dbl[PW-1:0];
    end
  end

  assign decay_prod = 60'(chase_speed) * 60'(ssfg_pkg::DECAY_MUL);
  assign decay_hi = decay_prod[59:32];

  assign fade_diff = (fade_level > fade_chase) ? (fade_level - fade_chase)
                                               : (fade_chase - fade_level);
  assign fade_prod = 57'(fade_diff) * 57'(fade_rate);
  assign fade_sum = 58'(fade_prod) + ssfg_pkg::FADE_ROUND;
  assign fade_step = fade_sum[56:32];

  assign gain_diff = (last_target > gain_chase) ? (last_target - gain_chase)
                                                : (gain_chase - last_target);
  assign den = ssfg_pkg::DEN_W'(chase_speed) + ssfg_pkg::ONE_Q16;
  assign num = ssfg_pkg::NUM_W'({gain_diff, 16'b0}) + ssfg_pkg::NUM_W'(den)
             - ssfg_pkg::NUM_W'(1);
  assign div_start = (state == ST_DIVLOAD);

  assign gain_round = 57'(prod_r) + ssfg_pkg::GAIN_ROUND;
  assign lane_ctl.start = (state == ST_SCALE);
  assign lane_ctl.unity = (prod_r == ssfg_pkg::UNITY_PRODUCT);
  assign lane_ctl.dither_enable = dither_enable;
  assign lane_ctl.gain = gain_round[55:24];

  ssfg_divider u_divider (
    .clk   (clk),
    .rst   (rst),
    .start (div_start),
    .num   (num),
    .den   (den),
    .done  (div_done),
    .quot  (quot)
  );

  ssfg_lane u_lane_left (
    .clk        (clk),
    .rst        (rst),
    .ctl        (lane_ctl),
    .seed_reset (ssfg_pkg::SEED_LEFT_RESET),
    .sample     (samp_l),
    .done       (lane_l_done),
    .result     (lane_l_result)
  );

  ssfg_lane u_lane_right (
    .clk        (clk),
    .rst        (rst),
    .ctl        (lane_ctl),
    .seed_reset (ssfg_pkg::SEED_RIGHT_RESET),
    .sample     (samp_r),
    .done       (lane_r_done),
    .result     (lane_r_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      target_gain <= ssfg_pkg::TARGET_GAIN_RESET;
      fade_level <= ssfg_pkg::FADE_LEVEL_RESET;
      fade_rate <= ssfg_pkg::FADE_RATE_RESET;
      dither_enable <= 1'b1;
    end else if (cfg_write) begin
      unique case (cfg_index)
        ssfg_pkg::REG_TARGET_GAIN:   target_gain <= cfg_data[GW-1:0];
        ssfg_pkg::REG_FADE_LEVEL:    fade_level <= cfg_data[FW-1:0];
        ssfg_pkg::REG_FADE_RATE:     fade_rate <= cfg_data;
        ssfg_pkg::REG_DITHER_ENABLE: dither_enable <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      chase_speed <= ssfg_pkg::SPEED_FLOOR;
      last_target <= '0;
      gain_chase <= '0;
      fade_chase <= '0;
      primed <= 1'b0;
      result_valid <= 1'b0;
    end else begin
      if (result_valid && !result_stall && (state != ST_OUT)) begin
        result_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (accept) begin
            samp_l <= sample_item.sample_left;
            samp_r <= sample_item.sample_right;
            chase_speed <= speed_blk;
            if (sample_item.block_first && (target_gain != last_target)) begin
              last_target <= target_gain;
            end
            if (!primed) begin
              gain_chase <= target_gain;
              fade_chase <= fade_level;
              primed <= 1'b1;
            end
            state <= ST_DECAY;
          end
        end
        ST_DECAY: begin
          chase_speed <= (decay_hi > ssfg_pkg::DECAY_LIMIT) ? (decay_hi - ssfg_pkg::DECAY_SUB)
                                                            : ssfg_pkg::SPEED_FLOOR;
          if (fade_level > fade_chase) begin
            fade_chase <= fade_chase + fade_step;
          end else begin
            fade_chase <= fade_chase - fade_step;
          end
          state <= ST_DIVLOAD;
        end
        ST_DIVLOAD: begin
          dir_up <= (last_target > gain_chase);
          state <= ST_DIV;
        end
        ST_DIV: begin
          if (div_done) begin
            if (dir_up) begin
              gain_chase <= gain_chase + GW'(quot);
            end else begin
              gain_chase <= gain_chase - GW'(quot);
            end
            state <= ST_PROD;
          end
        end
        ST_PROD: begin
          prod_r <= 56'(gain_chase) * 56'(fade_chase);
          state <= ST_SCALE;
        end
        ST_SCALE: begin
          state <= ST_LANE;
        end
        ST_LANE: begin
          if (lane_l_done && lane_r_done) begin
            state <= ST_OUT;
          end
        end
        ST_OUT: begin
          if (!result_valid || !result_stall) begin
            result_item.out_left <= lane_l_result;
            result_item.out_right <= lane_r_result;
            result_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

`ifndef SYNTH
  a_speed_range: assert property (@(posedge clk) disable iff (rst)
      (state == ST_DIVLOAD) |->
      (chase_speed >= ssfg_pkg::SPEED_FLOOR && chase_speed <= ssfg_pkg::SPEED_CAP))
    else $error("Chase speed outside its floor and cap before division.");
  a_div_phase: assert property (@(posedge clk) disable iff (rst)
      div_done |-> (state == ST_DIV))
    else $error("Divider finished outside the division phase.");
  a_result_src: assert property (@(posedge clk) disable iff (rst)
      $rose(result_valid) |-> ($past(state) == ST_OUT))
    else $error("Result item raised outside the output phase.");
`endif

endmodule

>>> sim/smoothed_stereo_fader_gain_tb.sv
// Self-checking testbench for smoothed_stereo_fader_gain: stereo items go in through a bursty
// driver, results are stalled on a pattern of their own and compared with an in-bench predictor.
// Depends on ssfg_pkg and the smoothed_stereo_fader_gain RTL.
module smoothed_stereo_fader_gain_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SAMPLE_WIDTH = ssfg_pkg::SAMPLE_WIDTH;
  localparam int LATENCY = 16;
  localparam int CYCLE_LIMIT = 600000;
  localparam int RANDOM_ITEMS = 800;

  localparam logic [63:0] FLOOR_Q16 = 64'd350 << 16;
  localparam logic [63:0] CAP_Q16 = 64'd2500 << 16;
  localparam logic [63:0] DECAY_FACTOR = 64'd4294537799;
  localparam logic [63:0] DECAY_STEP = 64'd655;
  localparam logic [63:0] UNITY_Q48 = 64'd1 << 48;
  localparam longint S_MAX_L = (longint'(1) <<< (SAMPLE_WIDTH - 1)) - 1;
  localparam longint S_MIN_L = -S_MAX_L - 1;
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MAX = {1'b0, {(SAMPLE_WIDTH - 1){1'b1}}};
  localparam logic signed [SAMPLE_WIDTH-1:0] S_MIN = {1'b1, {(SAMPLE_WIDTH - 1){1'b0}}};

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [ssfg_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [ssfg_pkg::CFG_DATA_W-1:0] cfg_data = '0;
  logic sample_valid = 1'b0;
  logic sample_stall;
  ssfg_pkg::sample_item_t sample_item = '0;
  logic result_valid;
  logic result_stall = 1'b0;
  ssfg_pkg::result_item_t result_item;

  // Register copies and smoother state of the predictor.
  logic [30:0] target_reg;
  logic [24:0] fade_level_reg;
  logic [31:0] fade_rate_reg;
  logic dither_on;
  logic [63:0] speed_q16, held_target, gain_q24, fade_q24;
  logic primed;
  logic [31:0] seed_l, seed_r;

  ssfg_pkg::sample_item_t pending_pairs[$];
  ssfg_pkg::result_item_t expected_pairs[$];
  int items_queued = 0;
  int results_seen = 0;
  int fails = 0;
  int unity_count = 0;
  int plain_count = 0;
  int settings = 1;
  int gap_left = 0;
  int burst_left = 8;
  int stall_tick = 0;
  int stall_mode = 0;
  int cycle_count = 0;

  smoothed_stereo_fader_gain dut (
    .clk(clk),
    .rst(rst),
    .cfg_write(cfg_write),
    .cfg_index(cfg_index),
    .cfg_data(cfg_data),
    .sample_valid(sample_valid),
    .sample_stall(sample_stall),
    .sample_item(sample_item),
    .result_valid(result_valid),
    .result_stall(result_stall),
    .result_item(result_item)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic logic [31:0] xorshift32(logic [31:0] s);
    s ^= s << 13;
    s ^= s >> 17;
    s ^= s << 5;
    return s;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] scale_sample(
      logic signed [SAMPLE_WIDTH-1:0] s, logic [63:0] g, logic [31:0] seed);
    longint acc;
    acc = longint'(s) * longint'(g);
    acc += dither_on ? longint'({32'd0, seed >> 8}) : 64'sd8388608;
    acc = acc >>> 24;
    if (acc > S_MAX_L) acc = S_MAX_L;
    else if (acc < S_MIN_L) acc = S_MIN_L;
    return acc[SAMPLE_WIDTH-1:0];
  endfunction

  function automatic ssfg_pkg::result_item_t predict_pair(ssfg_pkg::sample_item_t it);
    logic [63:0] den, step, prod, g;
    ssfg_pkg::result_item_t r;
    if (it.block_first) begin
      if (64'(target_reg) != held_target) begin
        speed_q16 = speed_q16 * 2;
        held_target = 64'(target_reg);
      end
      if (speed_q16 > CAP_Q16) speed_q16 = CAP_Q16;
    end
    if (!primed) begin
      gain_q24 = 64'(target_reg);
      fade_q24 = 64'(fade_level_reg);
      primed = 1'b1;
    end
    speed_q16 = (speed_q16 * DECAY_FACTOR) >> 32;
    speed_q16 = (speed_q16 > FLOOR_Q16 + DECAY_STEP) ? speed_q16 - DECAY_STEP : FLOOR_Q16;
    den = speed_q16 + 64'd65536;
    if (held_target > gain_q24) begin
      step = (((held_target - gain_q24) << 16) + den - 1) / den;
      gain_q24 += step;
    end else if (held_target < gain_q24) begin
      step = (((gain_q24 - held_target) << 16) + den - 1) / den;
      gain_q24 -= step;
    end
    if (64'(fade_level_reg) > fade_q24) begin
      step = ((64'(fade_level_reg) - fade_q24) * 64'(fade_rate_reg) + 64'hFFFF_FFFF) >> 32;
      fade_q24 += step;
    end else if (64'(fade_level_reg) < fade_q24) begin
      step = ((fade_q24 - 64'(fade_level_reg)) * 64'(fade_rate_reg) + 64'hFFFF_FFFF) >> 32;
      fade_q24 -= step;
    end
    prod = gain_q24 * fade_q24;
    if (prod == UNITY_Q48) begin
      unity_count++;
      r.out_left = it.sample_left;
      r.out_right = it.sample_right;
      return r;
    end
    if (!dither_on) plain_count++;
    g = (prod + (64'd1 << 23)) >> 24;
    seed_l = xorshift32(seed_l);
    seed_r = xorshift32(seed_r);
    r.out_left = scale_sample(it.sample_left, g, seed_l);
    r.out_right = scale_sample(it.sample_right, g, seed_r);
    return r;
  endfunction

  function automatic logic signed [SAMPLE_WIDTH-1:0] rand_sample();
    logic signed [SAMPLE_WIDTH-1:0] v;
    v = SAMPLE_WIDTH'($urandom());
    case ($urandom_range(0, 7))
      0: v = S_MAX;
      1: v = S_MIN;
      2, 3: v = v >>> $urandom_range(4, 20);
      default: ;
    endcase
    return v;
  endfunction

  task automatic queue_pair(logic signed [SAMPLE_WIDTH-1:0] left,
                            logic signed [SAMPLE_WIDTH-1:0] right, logic first);
    ssfg_pkg::sample_item_t it;
    it.sample_left = left;
    it.sample_right = right;
    it.block_first = first;
    pending_pairs.push_back(it);
    items_queued++;
  endtask

  task automatic write_reg(ssfg_pkg::cfg_reg_t idx, logic [31:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_write <= 1'b0;
    case (idx)
      ssfg_pkg::REG_TARGET_GAIN: target_reg = val[30:0];
      ssfg_pkg::REG_FADE_LEVEL: fade_level_reg = val[24:0];
      ssfg_pkg::REG_FADE_RATE: fade_rate_reg = val;
      default: dither_on = val[0];
    endcase
  endtask

  task automatic settle();
    while (results_seen != items_queued) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  always @(posedge clk) begin
    if (rst) begin
      sample_valid <= 1'b0;
    end else begin
      if (sample_valid && !sample_stall) begin
        expected_pairs.push_back(predict_pair(sample_item));
      end
      if (!sample_valid || !sample_stall) begin
        if (gap_left != 0 || pending_pairs.size() == 0) begin
          if (gap_left != 0) gap_left--;
          sample_valid <= 1'b0;
        end else begin
          sample_item <= pending_pairs.pop_front();
          sample_valid <= 1'b1;
          burst_left--;
          if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    ssfg_pkg::result_item_t want;
    if (rst) begin
      result_stall <= 1'b0;
    end else begin
      if (result_valid && !result_stall) begin
        if (expected_pairs.size() == 0) begin
          $error("unexpected result item: out_left %0d, out_right %0d",
                 result_item.out_left, result_item.out_right);
          fails++;
        end else begin
          want = expected_pairs.pop_front();
          if (result_item.out_left !== want.out_left) begin
            $error("out_left: expected %0d, got %0d", want.out_left, result_item.out_left);
            fails++;
          end
          if (result_item.out_right !== want.out_right) begin
            $error("out_right: expected %0d, got %0d", want.out_right, result_item.out_right);
            fails++;
          end
          results_seen++;
        end
      end
      stall_tick++;
      if (stall_tick % 300 == 0) stall_mode = $urandom_range(0, 3);
      case (stall_mode)
        0: result_stall <= 1'b0;
        1: result_stall <= ($urandom_range(0, 2) == 0);
        2: result_stall <= (stall_tick % 7 < 3);
        default: result_stall <= (stall_tick % 64 < 40);
      endcase
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    int rand_items;
    int n_items;
    int blk_left;
    logic first;
    logic [31:0] val;
    rand_items = 0;
    target_reg = 31'd16777216;
    fade_level_reg = 25'd16777216;
    fade_rate_reg = 32'd24210639;
    dither_on = 1'b1;
    speed_q16 = FLOOR_Q16;
    held_target = '0;
    gain_q24 = '0;
    fade_q24 = '0;
    primed = 1'b0;
    seed_l = 32'h1234_5678;
    seed_r = 32'h8765_4321;
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Reset settings: the first block start lands exactly on unity gain.
    queue_pair(S_MAX, S_MIN, 1'b1);
    queue_pair(S_MIN, S_MAX, 1'b0);
    queue_pair('0, -1, 1'b0);
    queue_pair(1, -2, 1'b1);
    settle();

    // Largest target with dither off and the fade rate at its maximum: samples clip.
    write_reg(ssfg_pkg::REG_TARGET_GAIN, 32'h7FFF_FFFF);
    write_reg(ssfg_pkg::REG_FADE_RATE, 32'hFFFF_FFFF);
    write_reg(ssfg_pkg::REG_DITHER_ENABLE, 32'd0);
    settings++;
    queue_pair(S_MAX, S_MIN, 1'b1);
    queue_pair(S_MIN, S_MAX, 1'b0);
    queue_pair(S_MAX, S_MAX, 1'b0);
    queue_pair(-1, '0, 1'b0);
    queue_pair(S_MIN, S_MIN, 1'b0);
    settle();

    // Zero target and level with the fade frozen; the chase speed reaches its cap.
    write_reg(ssfg_pkg::REG_TARGET_GAIN, 32'd0);
    write_reg(ssfg_pkg::REG_FADE_LEVEL, 32'd0);
    write_reg(ssfg_pkg::REG_FADE_RATE, 32'd0);
    write_reg(ssfg_pkg::REG_DITHER_ENABLE, 32'd1);
    settings++;
    queue_pair(S_MAX, S_MIN, 1'b1);
    queue_pair(S_MIN, S_MAX, 1'b0);
    queue_pair(1, -1, 1'b0);
    queue_pair(S_MAX, '0, 1'b1);
    settle();

    // Smallest nonzero target with a fade level above unity.
    write_reg(ssfg_pkg::REG_TARGET_GAIN, 32'd167772);
    write_reg(ssfg_pkg::REG_FADE_LEVEL, 32'h01FF_FFFF);
    write_reg(ssfg_pkg::REG_FADE_RATE, 32'h8000_0000);
    settings++;
    queue_pair(S_MAX, S_MIN, 1'b1);
    queue_pair(S_MIN, S_MAX, 1'b0);
    queue_pair('0, '0, 1'b0);
    queue_pair(-1, 1, 1'b1);
    queue_pair(S_MAX, S_MAX, 1'b0);
    settle();

    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 3) != 0) begin
        case ($urandom_range(0, 7))
          0: val = 32'd0;
          1: val = 32'h7FFF_FFFF;
          2: val = 32'd16777216;
          3: val = 32'd167772;
          4: val = 32'd1677721600;
          5, 6: val = $urandom_range(8388608, 33554432);
          default: val = $urandom_range(167772, 1677721600);
        endcase
        write_reg(ssfg_pkg::REG_TARGET_GAIN, val);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 3))
          0: val = 32'd0;
          1: val = 32'd16777216;
          2: val = 32'h01FF_FFFF;
          default: val = $urandom_range(0, 16777216);
        endcase
        write_reg(ssfg_pkg::REG_FADE_LEVEL, val);
      end
      if ($urandom_range(0, 1) != 0) begin
        case ($urandom_range(0, 5))
          0: val = 32'd0;
          1: val = 32'd1;
          2: val = 32'h8000_0000;
          3: val = 32'hFFFF_FFFF;
          4: val = $urandom();
          default: val = $urandom_range(1, 32'h8000_0000);
        endcase
        write_reg(ssfg_pkg::REG_FADE_RATE, val);
      end
      if ($urandom_range(0, 1) != 0) begin
        write_reg(ssfg_pkg::REG_DITHER_ENABLE, $urandom_range(0, 1));
      end
      settings++;
      n_items = $urandom_range(20, 80);
      blk_left = 0;
      for (int i = 0; i < n_items; i++) begin
        first = 1'b0;
        if (blk_left == 0) begin
          first = ($urandom_range(0, 5) != 0);
          blk_left = $urandom_range(4, 40);
        end else if ($urandom_range(0, 24) == 0) begin
          first = 1'b1;
        end
        blk_left--;
        queue_pair(rand_sample(), rand_sample(), first);
      end
      rand_items += n_items;
      settle();
    end

    repeat (2 * LATENCY) @(posedge clk);
    $display("Checked %0d stereo items against the predicted output over %0d register settings.",
             results_seen, settings);
    $display("%0d items came out at exact unity gain and %0d were rounded without dither.",
             unity_count, plain_count);
    if (fails == 0 && expected_pairs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

>>> files.f
design/ssfg_pkg.sv
design/ssfg_divider.sv
design/ssfg_lane.sv
design/smoothed_stereo_fader_gain.sv
sim/smoothed_stereo_fader_gain_tb.sv
